// ===== rtl/core/sbr_pkg.sv =====
// shared budget rebalancer: package with opcodes, error codes, cell actions
// and the control and flag bundles between the head unit and the controller
// no dependencies
package sbr_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int SIZE_BITS_DEF = 40;

  // event opcodes
  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_BUDGET   = 2'd3
  } op_t;

  // result error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_BUSY  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // what the head unit does to the slot that matches the target
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_SUB   = 2'd3
  } act_t;

  // configuration register indexes
  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_CAP    = 1'b1;

  typedef struct packed {
    act_t act;
    logic hit;
    logic first;
    op_t  op;
  } sbr_ctl_t;

  typedef struct packed {
    logic err_busy;
    logic err_empty;
    logic sur_ok;
    logic def_ok;
    logic sho_ok;
    logic changed;
  } sbr_flags_t;

endpackage

// ===== rtl/core/shared_budget_rebalancer.sv =====
// shared budget rebalancer: top level with the slot ring, the controller and
// the stream ports; depends on sbr_pkg, sbr_cell and sbr_head
//
// Each event takes a number of ring passes, with a decision step between
// passes: one pass applies the event and gathers sums, then one pass per
// rebalance step (a revoke, a grant to a slot short of its requirement or a
// grant toward a desired amount; each step settles a slot, so at most about
// 3*NUM_SLOTS steps), then an output pass that sends one beat per slot whose
// grant changed, in slot order, and a summary beat.
// A quiet event goes through a set-up step, two passes, four decision steps
// and the summary before the block is idle again and the next beat can be
// taken; output stalls stretch the output pass. The slot ring, where every
// slot passes the single head unit once per pass, sets the length of an event.
// No clearing pass is needed after reset. Input beats are taken only while
// the block is idle.
module shared_budget_rebalancer #(
  parameter int NUM_SLOTS = sbr_pkg::NUM_SLOTS_DEF,
  parameter int SIZE_BITS = sbr_pkg::SIZE_BITS_DEF,
  localparam int IN_W  = ((4 * SIZE_BITS + 4 + 7) / 8) * 8,
  localparam int OUT_W = ((4 * SIZE_BITS + 15 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  // event stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // slot, requested_size, required_size, desired_size, new_total
  input  logic [IN_W-1:0]      s_tdata,
  // opcode, has_request
  input  logic [2:0]           s_tuser,
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // grant_slot, granted_size, free_memory, sum_required, sum_desired, error_code
  output logic [OUT_W-1:0]     m_tdata,
  // is_summary
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);
  import sbr_pkg::*;

  localparam int S   = SIZE_BITS;
  localparam int PW  = $clog2(NUM_SLOTS);
  localparam int CW  = (PW > 4) ? PW : 4;
  localparam int UW  = S + 1;
  localparam int XW  = S + 2;
  localparam int DW  = S + 7;
  localparam int SW  = S + 4;
  localparam int OUT_BITS = 4 * S + 15;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_PASS   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_OUTP   = 6'b010000,
    ST_SUMM   = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    PH_INIT   = 4'b0001,
    PH_REVOKE = 4'b0010,
    PH_GRANT  = 4'b0100,
    PH_FILL   = 4'b1000
  } phase_t;

  state_t          st;
  phase_t          phase;
  logic [PW-1:0]   pos;
  logic            first;
  act_t            act;
  logic [CW-1:0]   tgt;
  logic [S-1:0]    amt;

  // latched event
  op_t             op_q;
  logic [3:0]      slot_q;
  logic            has_q;
  logic [S-1:0]    reqsz_q, req_q, des_q, nt_q;
  logic [S-1:0]    g_init;
  err_t            err;

  logic signed [UW-1:0] um, um_next;
  logic [S-1:0]    total, cap;
  logic [DW-1:0]   need, deficit;
  logic [SW-1:0]   sreq, sdes;

  logic            sur_found, def_found, sho_found;
  logic [S-1:0]    sur_best, def_best, sho_best;
  logic [PW-1:0]   sur_idx, def_idx, sho_idx;

  // ring wiring
  logic            c_live [NUM_SLOTS];
  logic [S-1:0]    c_req  [NUM_SLOTS];
  logic [S-1:0]    c_des  [NUM_SLOTS];
  logic [S-1:0]    c_gnt  [NUM_SLOTS];
  logic [S-1:0]    c_bef  [NUM_SLOTS];

  sbr_ctl_t        ctl;
  sbr_flags_t      hf;
  logic            h_live;
  logic [S-1:0]    h_req, h_des, h_gnt, h_bef, h_now, h_sur, h_def, h_sho;
  logic signed [XW-1:0] h_delta;

  logic            shift, out_free, load_chg, load_sum, pass_end;

  // output holding registers
  logic            o_sum;
  logic [3:0]      o_slot;
  logic [S-1:0]    o_gnt;
  logic [UW-1:0]   o_fm;
  logic [SW-1:0]   o_sreq, o_sdes;
  err_t            o_err;

  assign s_tready = (st == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign shift    = (st == ST_PASS) || ((st == ST_OUTP) && out_free);
  assign pass_end = (pos == PW'(NUM_SLOTS - 1));
  assign load_chg = (st == ST_OUTP) && out_free && hf.changed;
  assign load_sum = (st == ST_SUMM) && out_free;

  assign ctl.act   = act;
  assign ctl.hit   = (CW'(pos) == tgt);
  assign ctl.first = first;
  assign ctl.op    = op_q;

  // slot ring: cell 0 feeds the head, the head feeds the last cell
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
    logic          n_live;
    logic [S-1:0]  n_req, n_des, n_gnt, n_bef;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign n_live = h_live;
      assign n_req  = h_req;
      assign n_des  = h_des;
      assign n_gnt  = h_gnt;
      assign n_bef  = h_bef;
    end else begin : g_mid
      assign n_live = c_live[i+1];
      assign n_req  = c_req[i+1];
      assign n_des  = c_des[i+1];
      assign n_gnt  = c_gnt[i+1];
      assign n_bef  = c_bef[i+1];
    end
    sbr_cell #(.SIZE_BITS(S)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .live_in (n_live),
      .req_in  (n_req),
      .des_in  (n_des),
      .gnt_in  (n_gnt),
      .bef_in  (n_bef),
      .live    (c_live[i]),
      .req     (c_req[i]),
      .des     (c_des[i]),
      .gnt     (c_gnt[i]),
      .bef     (c_bef[i])
    );
  end

  sbr_head #(.SIZE_BITS(S)) u_head (
    .ctl      (ctl),
    .live_i   (c_live[0]),
    .req_i    (c_req[0]),
    .des_i    (c_des[0]),
    .gnt_i    (c_gnt[0]),
    .bef_i    (c_bef[0]),
    .evt_req  (req_q),
    .evt_des  (des_q),
    .g_init   (g_init),
    .amt      (amt),
    .live_o   (h_live),
    .req_o    (h_req),
    .des_o    (h_des),
    .gnt_o    (h_gnt),
    .bef_o    (h_bef),
    .now_v    (h_now),
    .sur_v    (h_sur),
    .def_v    (h_def),
    .sho_v    (h_sho),
    .um_delta (h_delta),
    .flags    (hf)
  );

  // initial grant for a registration
  logic [S-1:0]         g_cap, g_first;
  logic signed [XW-1:0] um_x;
  logic                 slot_ok, um_pos;
  always_comb begin
    um_x    = XW'(um);
    g_cap   = (reqsz_q < cap) ? reqsz_q : cap;
    g_first = has_q ? g_cap : cap;
    if (um < $signed({1'b0, g_first})) begin
      g_first = um[S] ? '0 : um[S-1:0];
    end
    slot_ok = (int'(slot_q) < NUM_SLOTS);
    um_pos  = !um[S] && (um != '0);
  end

  // rebalance step choice
  logic signed [DW+1:0] ndiff;
  logic [DW-1:0]        need_calc;
  logic [S-1:0]         take, add_g, add_f;
  logic                 rev_go, grt_go, fil_go;
  always_comb begin
    ndiff     = $signed({2'b00, deficit}) - (DW+2)'(um);
    need_calc = ndiff[DW+1] ? '0 : ndiff[DW-1:0];
    take      = (need < DW'(sur_best)) ? need[S-1:0] : sur_best;
    add_g     = (um[S-1:0] < def_best) ? um[S-1:0] : def_best;
    add_f     = (um[S-1:0] < sho_best) ? um[S-1:0] : sho_best;
    rev_go    = (need != '0) && sur_found && (sur_best != '0);
    grt_go    = um_pos && def_found;
    fil_go    = um_pos && sho_found;
  end

  // free memory update
  always_comb begin
    um_next = um;
    priority if (cfg_we && (cfg_index == CFG_BUDGET)) begin
      um_next = UW'(um_x + $signed({2'b00, cfg_data}) - $signed({2'b00, total}));
    end else if ((st == ST_PREP) && (op_q == OP_BUDGET)) begin
      um_next = UW'(um_x + $signed({2'b00, nt_q}) - $signed({2'b00, total}));
    end else if ((st == ST_PASS) && first && ctl.hit) begin
      um_next = UW'(um_x + h_delta);
    end else if ((st == ST_DECIDE) && (phase == PH_REVOKE) && rev_go) begin
      um_next = UW'(um_x + $signed({2'b00, take}));
    end else if ((st == ST_DECIDE) && (phase == PH_GRANT) && grt_go) begin
      um_next = UW'(um_x - $signed({2'b00, add_g}));
    end else if ((st == ST_DECIDE) && (phase == PH_FILL) && fil_go) begin
      um_next = UW'(um_x - $signed({2'b00, add_f}));
    end
  end

  // budget registers and free memory
  always_ff @(posedge clk) begin
    if (rst) begin
      um    <= '0;
      total <= '0;
      cap   <= '0;
    end else begin
      um <= um_next;
      if (cfg_we && (cfg_index == CFG_BUDGET)) begin
        total <= cfg_data;
      end else if ((st == ST_PREP) && (op_q == OP_BUDGET)) begin
        total <= nt_q;
      end
      if (cfg_we && (cfg_index == CFG_CAP)) begin
        cap <= cfg_data;
      end
    end
  end

  // event latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= op_t'(s_tuser[1:0]);
      has_q   <= s_tuser[2];
      slot_q  <= s_tdata[3:0];
      reqsz_q <= s_tdata[4 +: S];
      req_q   <= s_tdata[4 + S +: S];
      des_q   <= s_tdata[4 + 2*S +: S];
      nt_q    <= s_tdata[4 + 3*S +: S];
    end
    if (st == ST_PREP) begin
      g_init <= g_first;
    end
  end

  // per pass gathering: sums, deficit and the three selections
  logic start;
  assign start = (pos == '0);
  always_ff @(posedge clk) begin
    if (st == ST_PASS) begin
      sreq    <= (start ? '0 : sreq) + (h_live ? SW'(h_req) : '0);
      sdes    <= (start ? '0 : sdes) + (h_live ? SW'(h_des) : '0);
      deficit <= (start ? '0 : deficit) + (hf.def_ok ? DW'(h_def) : '0);
      if (hf.sur_ok && (start || !sur_found || (h_sur > sur_best))) begin
        sur_found <= 1'b1;
        sur_best  <= h_sur;
        sur_idx   <= pos;
      end else if (start) begin
        sur_found <= 1'b0;
      end
      if (hf.def_ok && (start || !def_found || (h_def < def_best))) begin
        def_found <= 1'b1;
        def_best  <= h_def;
        def_idx   <= pos;
      end else if (start) begin
        def_found <= 1'b0;
      end
      if (hf.sho_ok && (start || !sho_found || (h_sho < sho_best))) begin
        sho_found <= 1'b1;
        sho_best  <= h_sho;
        sho_idx   <= pos;
      end else if (start) begin
        sho_found <= 1'b0;
      end
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      phase <= PH_INIT;
      pos   <= '0;
      first <= 1'b0;
      act   <= ACT_NONE;
      tgt   <= '0;
      err   <= ERR_OK;
      need  <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            st <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (!slot_ok && (op_q == OP_REGISTER)) begin
            err <= ERR_BUSY;
          end else if (!slot_ok && (op_q == OP_REMOVE)) begin
            err <= ERR_EMPTY;
          end else begin
            err <= ERR_OK;
          end
          act   <= ACT_EVENT;
          tgt   <= CW'(slot_q);
          first <= 1'b1;
          phase <= PH_INIT;
          pos   <= '0;
          st    <= ST_PASS;
        end
        ST_PASS: begin
          if (first && hf.err_busy) begin
            err <= ERR_BUSY;
          end else if (first && hf.err_empty) begin
            err <= ERR_EMPTY;
          end
          if (pass_end) begin
            pos   <= '0;
            first <= 1'b0;
            st    <= ST_DECIDE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        ST_DECIDE: begin
          unique case (phase)
            PH_INIT: begin
              need  <= need_calc;
              phase <= PH_REVOKE;
            end
            PH_REVOKE: begin
              if (rev_go) begin
                act  <= ACT_SUB;
                tgt  <= CW'(sur_idx);
                amt  <= take;
                need <= need - DW'(take);
                st   <= ST_PASS;
              end else begin
                phase <= PH_GRANT;
              end
            end
            PH_GRANT: begin
              if (grt_go) begin
                act <= ACT_ADD;
                tgt <= CW'(def_idx);
                amt <= add_g;
                st  <= ST_PASS;
              end else begin
                phase <= PH_FILL;
              end
            end
            PH_FILL: begin
              if (fil_go) begin
                act <= ACT_ADD;
                tgt <= CW'(sho_idx);
                amt <= add_f;
                st  <= ST_PASS;
              end else begin
                act <= ACT_NONE;
                st  <= ST_OUTP;
              end
            end
            default: phase <= PH_INIT;
          endcase
        end
        ST_OUTP: begin
          if (out_free) begin
            if (pass_end) begin
              pos <= '0;
              st  <= ST_SUMM;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        ST_SUMM: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load_chg || load_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (load_chg || load_sum) begin
      o_sum  <= load_sum;
      o_slot <= load_sum ? 4'd0 : 4'(pos);
      o_gnt  <= load_sum ? '0 : h_now;
      o_fm   <= um;
      o_sreq <= sreq;
      o_sdes <= sdes;
      o_err  <= err;
    end
  end

  assign m_tdata  = OUT_W'({o_err, o_sdes, o_sreq, o_fm, o_gnt, o_slot});
  assign m_tuser  = o_sum;
  assign m_tlast  = o_sum;

  // each pass leaves the ring aligned with slot 0 at the head
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DECIDE) |-> (pos == '0))
    else $error("ring not aligned at pass end");

  // the rebalance never returns from the fill phase to an earlier phase within one event
  a_phase_fwd: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_FILL) && (st != ST_IDLE) && (st != ST_PREP)) |=> (phase == PH_FILL))
    else $error("rebalance phase went backwards");

  // no change beat is left waiting while a new event may be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tlast))
    else $error("change beat pending while idle");

endmodule

// ===== rtl/core/sbr_cell.sv =====
// shared budget rebalancer: one ring cell holding the amounts of one slot
// depends on sbr_pkg for the default width
module sbr_cell #(
  parameter int SIZE_BITS = sbr_pkg::SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 live_in,
  input  logic [SIZE_BITS-1:0] req_in,
  input  logic [SIZE_BITS-1:0] des_in,
  input  logic [SIZE_BITS-1:0] gnt_in,
  input  logic [SIZE_BITS-1:0] bef_in,
  output logic                 live,
  output logic [SIZE_BITS-1:0] req,
  output logic [SIZE_BITS-1:0] des,
  output logic [SIZE_BITS-1:0] gnt,
  output logic [SIZE_BITS-1:0] bef
);

  // live flag, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= live_in;
    end
  end

  // amounts move along the ring with the flag
  always_ff @(posedge clk) begin
    if (shift) begin
      req <= req_in;
      des <= des_in;
      gnt <= gnt_in;
      bef <= bef_in;
    end
  end

endmodule

// ===== rtl/core/sbr_head.sv =====
// shared budget rebalancer: head unit at the ring entry, applies the pending
// change to the passing slot and derives its surplus, deficit and shortfall
// depends on sbr_pkg
module sbr_head #(
  parameter int SIZE_BITS = sbr_pkg::SIZE_BITS_DEF
) (
  input  sbr_pkg::sbr_ctl_t           ctl,
  input  logic                        live_i,
  input  logic [SIZE_BITS-1:0]        req_i,
  input  logic [SIZE_BITS-1:0]        des_i,
  input  logic [SIZE_BITS-1:0]        gnt_i,
  input  logic [SIZE_BITS-1:0]        bef_i,
  input  logic [SIZE_BITS-1:0]        evt_req,
  input  logic [SIZE_BITS-1:0]        evt_des,
  input  logic [SIZE_BITS-1:0]        g_init,
  input  logic [SIZE_BITS-1:0]        amt,
  output logic                        live_o,
  output logic [SIZE_BITS-1:0]        req_o,
  output logic [SIZE_BITS-1:0]        des_o,
  output logic [SIZE_BITS-1:0]        gnt_o,
  output logic [SIZE_BITS-1:0]        bef_o,
  output logic [SIZE_BITS-1:0]        now_v,
  output logic [SIZE_BITS-1:0]        sur_v,
  output logic [SIZE_BITS-1:0]        def_v,
  output logic [SIZE_BITS-1:0]        sho_v,
  output logic signed [SIZE_BITS+1:0] um_delta,
  output sbr_pkg::sbr_flags_t         flags
);
  import sbr_pkg::*;

  logic [SIZE_BITS-1:0] des_new;
  logic [SIZE_BITS-1:0] g_t;
  logic                 busy_hit;
  logic                 empty_hit;

  // apply the event or the pending grant change
  always_comb begin
    live_o    = live_i;
    req_o     = req_i;
    des_o     = des_i;
    gnt_o     = gnt_i;
    um_delta  = '0;
    busy_hit  = 1'b0;
    empty_hit = 1'b0;
    des_new   = (evt_des < evt_req) ? evt_req : evt_des;
    g_t       = (g_init < des_new) ? g_init : des_new;
    if (ctl.hit) begin
      unique case (ctl.act)
        ACT_EVENT: begin
          unique case (ctl.op)
            OP_REGISTER: begin
              if (live_i) begin
                busy_hit = 1'b1;
              end else begin
                live_o   = 1'b1;
                req_o    = evt_req;
                des_o    = des_new;
                gnt_o    = g_t;
                um_delta = -$signed({2'b00, g_t});
              end
            end
            OP_UPDATE: begin
              if (live_i) begin
                req_o = evt_req;
                des_o = des_new;
                if (gnt_i > des_new) begin
                  gnt_o    = des_new;
                  um_delta = $signed({2'b00, gnt_i - des_new});
                end
              end
            end
            OP_REMOVE: begin
              if (!live_i) begin
                empty_hit = 1'b1;
              end else begin
                live_o   = 1'b0;
                req_o    = '0;
                des_o    = '0;
                gnt_o    = '0;
                um_delta = $signed({2'b00, gnt_i});
              end
            end
            OP_BUDGET: begin
            end
          endcase
        end
        ACT_ADD:  gnt_o = gnt_i + amt;
        ACT_SUB:  gnt_o = gnt_i - amt;
        ACT_NONE: begin
        end
      endcase
    end
  end

  // candidate values for the three selections and the change marker
  always_comb begin
    sur_v = gnt_o - req_o;
    def_v = req_o - gnt_o;
    sho_v = des_o - gnt_o;
    flags.err_busy  = busy_hit;
    flags.err_empty = empty_hit;
    flags.sur_ok    = live_o && (gnt_o >= req_o);
    flags.def_ok    = live_o && (gnt_o < req_o);
    flags.sho_ok    = live_o && (gnt_o < des_o);
    now_v = live_o ? gnt_o : '0;
    bef_o = ctl.first ? (live_i ? gnt_i : '0) : bef_i;
    flags.changed = (now_v != bef_o);
  end

endmodule
